// File: rtl/smcp_pkg.sv
// Package for the serial move command parser.
// Holds reply codes, character constants and the types shared by the parser,
// the result queue and the top level. No dependencies.
package smcp_pkg;

    typedef enum logic [2:0] {
        RPL_OK   = 3'd0,
        RPL_PONG = 3'd1,
        RPL_ERR  = 3'd2,
        RPL_BUSY = 3'd3,
        RPL_MOVE = 3'd4
    } reply_t;

    typedef enum logic [1:0] {
        FW_NONE = 2'd0,
        FW_PING = 2'd1,
        FW_MOVE = 2'd2
    } first_word_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_P     = 8'h50;

    localparam logic [31:0] WORD_PING = "PING";
    localparam logic [31:0] WORD_MOVE = "MOVE";

    localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;
    localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;

    // Per-line parse state, cleared at every line end.
    typedef struct packed {
        logic        text_ended;
        logic        inside_token;
        logic [1:0]  token_count;
        logic [2:0]  token_char_pos;
        first_word_t first_word_match;
        logic        number_negative;
        logic        number_has_digit;
        logic        number_invalid;
        logic [31:0] number_magnitude;
        logic [31:0] pan_value;
    } line_st_t;

    typedef struct packed {
        reply_t      reply;
        logic [31:0] pan_count;
        logic [31:0] tilt_count;
        logic        last_of_run;
    } result_t;

    // Results caused by one input word: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

// File: rtl/serial_move_command_parser.sv
// Top level of the serial move command parser: stream ports, input register,
// parser core and result queue. Depends on smcp_pkg, smcp_line_parser and
// smcp_result_queue.
//
// Accepts one word per cycle: a received serial byte (s_tuser low) or a
// status tick (s_tuser high), each with the current motion busy flag. Bytes
// build lines ending at CR or LF; a line of PING answers PONG, a line
// "MOVE <pan> <tilt>" with base-10 signed integers (clamped to 32 bits)
// gives a start move request, or BUSY while motion is busy, and any other
// non-blank line answers ERR. Lines longer than LINE_CHARS-1 bytes are
// dropped without a reply. Whenever a move is pending and a word arrives
// with motion idle, OK goes out first. A word passes through the input
// register, then the parse into the result queue, before its first result
// appears; the parse itself handles one word per cycle while the queue has
// room for two results. A word can yield up to two results, and the
// output drains one result per cycle while m_tready is high, so a run of
// two-result words slows input once the four-entry result queue fills.
// m_tlast marks the final result caused by one input word.
module serial_move_command_parser #(
    parameter int LINE_CHARS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [8] motion_busy, [15:9] zero
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [2:0] reply, [34:3] pan_count, [66:35] tilt_count,
                                   // [71:67] zero
    output logic        m_tlast    // last_of_run
);
    import smcp_pkg::*;

    logic         in_valid_reg;
    logic         func_reg;
    logic [7:0]   rx_byte_reg;
    logic         busy_reg;
    logic         room_two;
    logic         proc_fire;
    logic         s_fire;
    result_pair_t results;
    result_t      head;

    // Advance the input register when its word is parsed this cycle.
    assign proc_fire = in_valid_reg && room_two;
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Hold the payload until the parse takes it.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg    <= s_tuser;
            rx_byte_reg <= s_tdata[7:0];
            busy_reg    <= s_tdata[8];
        end
    end

    smcp_line_parser #(
        .LINE_CHARS(LINE_CHARS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (proc_fire),
        .func       (func_reg),
        .rx_byte    (rx_byte_reg),
        .motion_busy(busy_reg),
        .results    (results)
    );

    smcp_result_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (results),
        .room_two (room_two),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (head)
    );

    assign m_tdata = {5'd0, head.tilt_count, head.pan_count, 3'(head.reply)};
    assign m_tlast = head.last_of_run;

    assert property (@(posedge aclk) disable iff (!aresetn)
        !proc_fire |-> results.count == 2'd0)
        else $error("results produced without a parsed word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !room_two |=> in_valid_reg && $stable(rx_byte_reg))
        else $error("stalled input word lost");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !in_valid_reg)
        else $error("state not cleared by reset");

endmodule

// File: rtl/smcp_line_parser.sv
// Line parser core of the serial move command parser.
// Holds the line and move-pending state and turns one word into up to two
// results combinationally. Depends on smcp_pkg.
module smcp_line_parser #(
    parameter int LINE_CHARS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 func,
    input  logic [7:0]           rx_byte,
    input  logic                 motion_busy,
    output smcp_pkg::result_pair_t results
);
    import smcp_pkg::*;

    localparam int LEN_W = (LINE_CHARS > 2) ? $clog2(LINE_CHARS) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CHARS - 1);

    line_st_t         st_reg, st_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             discard_reg, discard_next;
    logic             pending_reg, pending_next;

    function automatic logic [31:0] clamp_value(line_st_t s);
        logic [31:0] v;
        if (s.number_negative) begin
            v = 32'd0 - s.number_magnitude;
        end else begin
            v = (s.number_magnitude > INT_MAX) ? INT_MAX : s.number_magnitude;
        end
        return v;
    endfunction

    function automatic line_st_t end_token(line_st_t s_in);
        line_st_t s;
        s = s_in;
        if (s.inside_token) begin
            s.inside_token = 1'b0;
            if (s.token_count == 2'd0) begin
                if (s.token_char_pos != 3'd4) begin
                    s.first_word_match = FW_NONE;
                end
            end else if (s.token_count <= 2'd2) begin
                if (!s.number_has_digit) begin
                    s.number_invalid = 1'b1;
                end
                if (s.token_count == 2'd1) begin
                    s.pan_value = clamp_value(s);
                end
            end
            if (s.token_count < 2'd3) begin
                s.token_count = s.token_count + 2'd1;
            end
        end
        return s;
    endfunction

    function automatic line_st_t feed_char(line_st_t s_in, logic [7:0] ch);
        line_st_t    s;
        logic [35:0] mag;
        logic [1:0]  p;
        s   = s_in;
        mag = '0;
        p   = s_in.token_char_pos[1:0];
        if (!s.inside_token) begin
            s.inside_token   = 1'b1;
            s.token_char_pos = 3'd0;
            p                = 2'd0;
            if (s.token_count == 2'd1 || s.token_count == 2'd2) begin
                s.number_negative  = 1'b0;
                s.number_has_digit = 1'b0;
                s.number_magnitude = '0;
            end
        end
        if (s.token_count == 2'd0) begin
            if (s.token_char_pos == 3'd0) begin
                s.first_word_match = (ch == CH_P) ? FW_PING :
                                     (ch == CH_M) ? FW_MOVE : FW_NONE;
            end else if (s.token_char_pos < 3'd4) begin
                if (s.first_word_match == FW_PING && ch != WORD_PING[8*(3-p) +: 8]) begin
                    s.first_word_match = FW_NONE;
                end else if (s.first_word_match == FW_MOVE &&
                             ch != WORD_MOVE[8*(3-p) +: 8]) begin
                    s.first_word_match = FW_NONE;
                end
            end else begin
                s.first_word_match = FW_NONE;
            end
            if (s.token_char_pos < 3'd5) begin
                s.token_char_pos = s.token_char_pos + 3'd1;
            end
        end else if (s.token_count <= 2'd2) begin
            if (ch >= CH_0 && ch <= CH_9) begin
                // times ten as two shifts, then add the digit and saturate
                mag = ({4'd0, s.number_magnitude} << 3) + ({4'd0, s.number_magnitude} << 1)
                    + {32'd0, ch[3:0]};
                s.number_magnitude = (mag > MAG_LIMIT) ? MAG_LIMIT[31:0] : mag[31:0];
                s.number_has_digit = 1'b1;
                s.token_char_pos   = 3'd2;
            end else if (s.token_char_pos == 3'd0 && (ch == CH_VT || ch == CH_FF)) begin
                s.number_invalid = s.number_invalid;
            end else if (s.token_char_pos == 3'd0 && (ch == CH_PLUS || ch == CH_MINUS)) begin
                s.number_negative = (ch == CH_MINUS);
                s.token_char_pos  = 3'd1;
            end else begin
                s.number_invalid = 1'b1;
            end
        end
        return s;
    endfunction

    always_comb begin
        logic    ok_hit;
        logic    line_hit;
        result_t line_res;
        line_st_t s;

        st_next      = st_reg;
        len_next     = len_reg;
        discard_next = discard_reg;
        pending_next = pending_reg;
        ok_hit       = 1'b0;
        line_hit     = 1'b0;
        line_res     = '0;
        s            = st_reg;

        if (step) begin
            if (pending_reg && !motion_busy) begin
                pending_next = 1'b0;
                ok_hit       = 1'b1;
            end
            if (!func) begin
                if (rx_byte inside {CH_CR, CH_LF}) begin
                    if (discard_reg) begin
                        discard_next = 1'b0;
                        st_next      = '0;
                        len_next     = '0;
                    end else if (len_reg != '0) begin
                        s = end_token(st_reg);
                        if (s.token_count == 2'd0) begin
                            line_hit = 1'b0;
                        end else if (s.token_count == 2'd1 && s.first_word_match == FW_PING) begin
                            line_hit       = 1'b1;
                            line_res.reply = RPL_PONG;
                        end else if (s.token_count == 2'd3 && s.first_word_match == FW_MOVE &&
                                     !s.number_invalid) begin
                            line_hit = 1'b1;
                            if (motion_busy) begin
                                line_res.reply = RPL_BUSY;
                            end else begin
                                line_res.reply      = RPL_MOVE;
                                line_res.pan_count  = s.pan_value;
                                line_res.tilt_count = clamp_value(s);
                                pending_next        = 1'b1;
                            end
                        end else begin
                            line_hit       = 1'b1;
                            line_res.reply = RPL_ERR;
                        end
                        st_next  = '0;
                        len_next = '0;
                    end
                end else if (!discard_reg) begin
                    if (len_reg < LEN_MAX) begin
                        len_next = len_reg + LEN_W'(1);
                        if (!st_reg.text_ended) begin
                            if (rx_byte == CH_NUL) begin
                                st_next            = end_token(st_reg);
                                st_next.text_ended = 1'b1;
                            end else if (rx_byte inside {CH_SPACE, CH_TAB}) begin
                                st_next = end_token(st_reg);
                            end else begin
                                st_next = feed_char(st_reg, rx_byte);
                            end
                        end
                    end else begin
                        st_next      = '0;
                        len_next     = '0;
                        discard_next = 1'b1;
                    end
                end
            end
        end

        line_res.last_of_run = 1'b1;
        results.count  = {1'b0, ok_hit} + {1'b0, line_hit};
        results.second = line_res;
        if (ok_hit) begin
            results.first             = '0;
            results.first.reply       = RPL_OK;
            results.first.last_of_run = !line_hit;
        end else begin
            results.first = line_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= '0;
            len_reg     <= '0;
            discard_reg <= 1'b0;
            pending_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            len_reg     <= len_next;
            discard_reg <= discard_next;
            pending_reg <= pending_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        results.count == 2'd2 |-> results.first.reply == RPL_OK && !results.first.last_of_run)
        else $error("two results without leading OK");

    assert property (@(posedge aclk) disable iff (!aresetn)
        step && results.second.reply == RPL_MOVE && results.count != 2'd0 |=> pending_reg)
        else $error("move request did not set pending");

    assert property (@(posedge aclk) disable iff (!aresetn)
        discard_reg |-> len_reg == '0)
        else $error("discarded line kept a length");

endmodule

// File: rtl/smcp_result_queue.sv
// Result queue of the serial move command parser.
// Four-entry register queue that takes up to two results a cycle and hands
// out one while out_ready is high. Depends on smcp_pkg.
module smcp_result_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  smcp_pkg::result_pair_t   push,
    output logic                     room_two,
    output logic                     out_valid,
    input  logic                     out_ready,
    output smcp_pkg::result_t        out_data
);
    import smcp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign room_two  = (count_reg <= CNT_W'(DEPTH - 2));
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue count out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> count_reg <= CNT_W'(DEPTH) - CNT_W'(push.count))
        else $error("result queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("result queue pointers disagree with count");

endmodule

// File: tb/sv/tb_serial_move_command_parser.sv
// Self-checking testbench for serial_move_command_parser: streams serial bytes and status
// ticks into the parser and checks every reply word against an in-bench line parser.
// Depends on smcp_pkg and the serial_move_command_parser RTL.
module tb_serial_move_command_parser;
    import smcp_pkg::*;

    localparam int LINE_CHARS = 64;
    // Stop the run after this many cycles in which no word moves on either side
    localparam int IDLE_LIMIT = 2000;

    // One input word as the sender sees it
    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic       motion_busy;
    } serial_word_t;

    // One reply word as the parser should produce it
    typedef struct packed {
        reply_t      reply;
        logic [31:0] pan_count;
        logic [31:0] tilt_count;
        logic        last_of_run;
    } reply_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [7:0] rx_byte, [8] motion_busy, [15:9] zero
    logic        s_tuser = 1'b0; // [0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // [2:0] reply, [34:3] pan_count, [66:35] tilt_count
    logic        m_tlast;        // last_of_run

    serial_move_command_parser #(
        .LINE_CHARS(LINE_CHARS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    serial_word_t pending_words[$];
    reply_word_t  expected_replies[$];
    int           mismatches = 0;

    // ------------------------------------------------------------------
    // Line parser mirror: per-line state plus the move pending flag
    // ------------------------------------------------------------------
    logic [7:0]  line_len;
    logic        line_dropped;
    logic        text_done;
    logic        in_token;
    logic [1:0]  tokens_seen;
    logic [2:0]  token_pos;
    first_word_t word_match;
    logic        num_neg;
    logic        num_digits;
    logic        num_bad;
    logic [31:0] num_mag;
    logic [31:0] pan_held;
    logic        move_waiting;

    function automatic void clear_line_state();
        line_len   = '0;
        text_done  = 1'b0;
        in_token   = 1'b0;
        tokens_seen = '0;
        token_pos  = '0;
        word_match = FW_NONE;
        num_neg    = 1'b0;
        num_digits = 1'b0;
        num_bad    = 1'b0;
        num_mag    = '0;
        pan_held   = '0;
    endfunction

    // Signed value of the number token, clamped to the 32-bit range
    function automatic logic [31:0] clamped_number();
        if (num_neg)
            return -num_mag;
        return (num_mag > INT_MAX) ? INT_MAX : num_mag;
    endfunction

    function automatic void close_token();
        if (!in_token)
            return;
        in_token = 1'b0;
        if (tokens_seen == 2'd0) begin
            if (token_pos != 3'd4)
                word_match = FW_NONE;
        end else if (tokens_seen <= 2'd2) begin
            if (!num_digits)
                num_bad = 1'b1;
            if (tokens_seen == 2'd1)
                pan_held = clamped_number();
        end
        if (tokens_seen < 2'd3)
            tokens_seen = tokens_seen + 2'd1;
    endfunction

    function automatic void take_char(logic [7:0] ch);
        int          p;
        logic [35:0] grown;
        if (!in_token) begin
            in_token  = 1'b1;
            token_pos = '0;
            if (tokens_seen == 2'd1 || tokens_seen == 2'd2) begin
                num_neg    = 1'b0;
                num_digits = 1'b0;
                num_mag    = '0;
            end
        end
        p = token_pos;
        if (tokens_seen == 2'd0) begin
            // Track whether the first token still spells PING or MOVE
            if (p == 0) begin
                if (ch == CH_P)
                    word_match = FW_PING;
                else if (ch == CH_M)
                    word_match = FW_MOVE;
                else
                    word_match = FW_NONE;
            end else if (p < 4) begin
                if (word_match == FW_PING && ch != WORD_PING[(3 - p) * 8 +: 8])
                    word_match = FW_NONE;
                else if (word_match == FW_MOVE && ch != WORD_MOVE[(3 - p) * 8 +: 8])
                    word_match = FW_NONE;
            end else begin
                word_match = FW_NONE;
            end
            if (token_pos < 3'd5)
                token_pos = token_pos + 3'd1;
        end else if (tokens_seen <= 2'd2) begin
            if (ch >= CH_0 && ch <= CH_9) begin
                grown = {4'd0, num_mag} * 36'd10 + {28'd0, ch - CH_0};
                num_mag = (grown > MAG_LIMIT) ? MAG_LIMIT[31:0] : grown[31:0];
                num_digits = 1'b1;
                token_pos  = 3'd2;
            end else if (token_pos == 3'd0 && (ch == CH_VT || ch == CH_FF)) begin
                // leading vertical tab or form feed is skipped
            end else if (token_pos == 3'd0 && (ch == CH_PLUS || ch == CH_MINUS)) begin
                num_neg   = (ch == CH_MINUS);
                token_pos = 3'd1;
            end else begin
                num_bad = 1'b1;
            end
        end
    endfunction

    function automatic void queue_reply(reply_t code, logic [31:0] pan, logic [31:0] tilt);
        expected_replies.push_back(reply_word_t'{code, pan, tilt, 1'b0});
    endfunction

    // Work out the replies caused by one accepted word
    function automatic void parse_word(serial_word_t w);
        int count;
        count = 0;
        // A pending move is acknowledged before anything else on this word
        if (move_waiting && !w.motion_busy) begin
            move_waiting = 1'b0;
            queue_reply(RPL_OK, '0, '0);
            count++;
        end
        if (!w.func) begin
            if (w.rx_byte == CH_CR || w.rx_byte == CH_LF) begin
                if (line_dropped) begin
                    line_dropped = 1'b0;
                    clear_line_state();
                end else if (line_len != 0) begin
                    close_token();
                    if (tokens_seen == 2'd0) begin
                        // blank line: no reply
                    end else if (tokens_seen == 2'd1 && word_match == FW_PING) begin
                        queue_reply(RPL_PONG, '0, '0);
                        count++;
                    end else if (tokens_seen == 2'd3 && word_match == FW_MOVE && !num_bad) begin
                        if (w.motion_busy) begin
                            queue_reply(RPL_BUSY, '0, '0);
                        end else begin
                            queue_reply(RPL_MOVE, pan_held, clamped_number());
                            move_waiting = 1'b1;
                        end
                        count++;
                    end else begin
                        queue_reply(RPL_ERR, '0, '0);
                        count++;
                    end
                    clear_line_state();
                end
            end else if (!line_dropped) begin
                if (line_len < LINE_CHARS - 1) begin
                    line_len = line_len + 8'd1;
                    if (!text_done) begin
                        if (w.rx_byte == CH_NUL) begin
                            close_token();
                            text_done = 1'b1;
                        end else if (w.rx_byte == CH_SPACE || w.rx_byte == CH_TAB) begin
                            close_token();
                        end else begin
                            take_char(w.rx_byte);
                        end
                    end
                end else begin
                    clear_line_state();
                    line_dropped = 1'b1;
                end
            end
        end
        if (count > 0)
            expected_replies[expected_replies.size() - 1].last_of_run = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building: motion busy flag and stray ticks while random
    // ------------------------------------------------------------------
    logic motion = 1'b0;
    bit   scatter = 1'b0;

    task automatic add_word(logic func, logic [7:0] b);
        if (scatter && $urandom_range(0, 9) == 0)
            motion = ~motion;
        pending_words.push_back('{func, b, motion});
    endtask

    task automatic add_byte(logic [7:0] b);
        // Slip a status tick in now and then; it never touches the line
        if (scatter && $urandom_range(0, 11) == 0)
            add_word(1'b1, 8'($urandom_range(0, 255)));
        add_word(1'b0, b);
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic add_sep();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        repeat (n) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic end_line();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick <= 2) begin
            add_byte(CH_LF);
        end else if (pick <= 4) begin
            add_byte(CH_CR);
        end else begin
            add_byte(CH_CR);
            add_byte(CH_LF);
        end
    endtask

    task automatic add_junk_token(int n);
        repeat (n) add_byte(8'($urandom_range(8'h21, 8'h7E)));
    endtask

    // Well-formed number: optional skip byte, optional sign, digits
    task automatic add_number();
        string edges[6];
        int    kind;
        edges = '{"2147483647", "2147483648", "2147483649", "4294967295", "4294967296", "0"};
        kind  = $urandom_range(0, 9);
        if ($urandom_range(0, 7) == 0)
            add_byte($urandom_range(0, 1) ? CH_VT : CH_FF);
        case ($urandom_range(0, 2))
            0: add_byte(CH_PLUS);
            1: add_byte(CH_MINUS);
            default: ;
        endcase
        if (kind == 0) begin
            add_str(edges[$urandom_range(0, 5)]);
        end else begin
            repeat (kind < 7 ? $urandom_range(1, 4) : $urandom_range(5, 12))
                add_byte(CH_0 + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic add_bad_number();
        case ($urandom_range(0, 5))
            0: add_byte(CH_MINUS);
            1: begin add_byte(CH_PLUS); add_byte(CH_MINUS); add_str("4"); end
            2: begin add_str("12"); add_junk_token(1); end
            3: begin add_str("3"); add_byte(CH_MINUS); add_str("2"); end
            4: begin add_byte(CH_MINUS); add_byte(CH_VT); add_str("5"); end
            default: add_str("x9");
        endcase
    endtask

    task automatic add_random_line();
        int pick;
        int fill;
        pick = $urandom_range(0, 19);
        if (pick <= 6) begin
            // Move request, sometimes padded or with trailing tokens
            if ($urandom_range(0, 3) == 0) add_sep();
            add_str("MOVE");
            add_sep();
            add_number();
            add_sep();
            add_number();
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
                add_sep();
                add_junk_token($urandom_range(1, 5));
            end
            if ($urandom_range(0, 3) == 0) add_sep();
            end_line();
        end else if (pick <= 9) begin
            if ($urandom_range(0, 3) == 0) add_sep();
            add_str("PING");
            if ($urandom_range(0, 2) == 0) add_sep();
            end_line();
        end else if (pick == 10) begin
            add_str("PING");
            add_sep();
            add_junk_token($urandom_range(1, 4));
            end_line();
        end else if (pick <= 12) begin
            // Broken move: too few numbers or a malformed one
            add_str("MOVE");
            case ($urandom_range(0, 2))
                0: begin add_sep(); add_number(); end
                1: begin add_sep(); add_bad_number(); add_sep(); add_number(); end
                default: begin add_sep(); add_number(); add_sep(); add_bad_number(); end
            endcase
            end_line();
        end else if (pick == 13) begin
            case ($urandom_range(0, 4))
                0: add_str("MOVEX");
                1: add_str("PIN");
                2: add_str("PINGG");
                3: add_str("Move");
                default: add_junk_token($urandom_range(1, 6));
            endcase
            end_line();
        end else if (pick == 14) begin
            repeat ($urandom_range(0, 3)) add_sep();
            end_line();
        end else if (pick == 15) begin
            // NUL ends the text; what follows is counted but not parsed
            if ($urandom_range(0, 1)) begin
                add_str("PING");
            end else begin
                add_str("MOVE 7 -8");
            end
            add_byte(CH_NUL);
            add_junk_token($urandom_range(0, 4));
            end_line();
        end else if (pick == 16) begin
            // Length near the limit: kept or dropped
            fill = $urandom_range(LINE_CHARS - 6, LINE_CHARS + 6);
            add_str("PING");
            repeat (fill - 4) begin
                if ($urandom_range(0, 7) == 0)
                    add_junk_token(1);
                else
                    add_byte(CH_SPACE);
            end
            end_line();
        end else if (pick == 17) begin
            // Raw noise over the full byte range
            repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
            end_line();
        end else if (pick == 18) begin
            repeat ($urandom_range(1, 5)) add_word(1'b1, 8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(2, 3)) add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps between them
    // ------------------------------------------------------------------
    serial_word_t on_bus;
    int           burst_left = 0;
    int           gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                parse_word(on_bus);
            if (s_tvalid && !s_tready) begin
                // hold the word until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                on_bus = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, on_bus.motion_busy, on_bus.rx_byte};
                s_tuser  <= on_bus.func;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: a mode picked for a stretch of cycles
    // ------------------------------------------------------------------
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_phase = 0;

    always @(posedge aclk) begin
        logic rdy;
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
        end else begin
            rx_mode_left--;
        end
        rx_phase = (rx_phase + 1) % 4;
        case (rx_mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = (rx_phase == 3);
            default: rdy = ($urandom_range(0, 15) == 0);
        endcase
        m_tready <= rdy;
    end

    // ------------------------------------------------------------------
    // Monitor: compare each taken reply word with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        reply_word_t got;
        reply_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{reply_t'(m_tdata[2:0]), m_tdata[34:3], m_tdata[66:35], m_tlast};
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply word: reply %0d pan %0d tilt %0d last %0b",
                             got.reply, $signed(got.pan_count), $signed(got.tilt_count),
                             got.last_of_run);
            end else begin
                want = expected_replies.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"reply mismatch: expected reply %0d pan %0d tilt %0d last %0b,",
                                  " got reply %0d pan %0d tilt %0d last %0b"},
                                 want.reply, $signed(want.pan_count), $signed(want.tilt_count),
                                 want.last_of_run, got.reply, $signed(got.pan_count),
                                 $signed(got.tilt_count), got.last_of_run);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        clear_line_state();
        line_dropped = 1'b0;
        move_waiting = 1'b0;

        // Directed lines with the motion flag under direct control
        motion = 1'b0;
        add_str("PING"); add_byte(CH_LF);
        add_str("MOVE 2147483647 -2147483648"); add_byte(CH_CR);
        motion = 1'b1; add_word(1'b1, 8'hFF);
        motion = 1'b0; add_word(1'b1, 8'h00);          // acknowledge the move
        motion = 1'b1;
        add_str("MOVE +99999999999 -99999999999"); add_byte(CH_LF);  // busy
        motion = 1'b0;
        add_str("MOVE "); add_byte(CH_VT); add_str("2147483648 ");
        add_byte(CH_FF); add_str("-2147483649 extra 5"); add_byte(CH_LF);
        add_str("PING"); add_byte(CH_LF);              // OK then PONG
        add_byte(CH_LF);
        add_str(" \t "); add_byte(CH_CR);
        add_str("PING"); add_byte(CH_NUL); add_str("junk"); add_byte(CH_LF);
        add_byte(CH_NUL); add_str("MOVE 1 2"); add_byte(CH_LF);
        add_str("MOVE 1"); add_byte(CH_LF);
        add_str("MOVE 1 x2"); add_byte(CH_LF);
        add_str("MOVE - 3"); add_byte(CH_LF);
        add_str("PINGS"); add_byte(CH_LF);
        // Longest kept line, then one byte too long
        add_str("PING"); repeat (LINE_CHARS - 5) add_byte(CH_SPACE); add_byte(CH_LF);
        add_str("PING"); repeat (LINE_CHARS - 4) add_byte(CH_SPACE); add_byte(CH_LF);
        add_str("PING"); add_byte(CH_LF);

        // Random lines with stray ticks and a wandering busy flag
        scatter = 1'b1;
        while (pending_words.size() < 1800)
            add_random_line();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every word to go in and every reply to come out
        while (pending_words.size() != 0 || s_tvalid || expected_replies.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
rtl/smcp_pkg.sv
rtl/smcp_line_parser.sv
rtl/smcp_result_queue.sv
rtl/serial_move_command_parser.sv
tb/sv/tb_serial_move_command_parser.sv
